// ----- hdl/pdsc_pkg.sv -----
// Package for the packet deframer with 8-bit sum check.
// Holds result kinds, register indexes, state codes and reset values.
// No dependencies.
package pdsc_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 6;
    localparam int IDX_W   = 5;
    localparam int KIND_W  = 3;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [BYTE_W-1:0] SYNC_HDR_RST  = 8'd35;
    localparam logic [BYTE_W-1:0] ASYNC_HDR_RST = 8'd42;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST   = 6'd32;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_EMPTY     = 3'd1,
        KIND_HDR_ERR   = 3'd2,
        KIND_LEN_ERR   = 3'd3,
        KIND_SUM_ERR   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        REG_SYNC_HDR  = 2'd0,
        REG_ASYNC_HDR = 2'd1,
        REG_MAX_LEN   = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_HDR  = 4'b0001,
        ST_LEN  = 4'b0010,
        ST_PAY  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

endpackage

// ----- hdl/packet_deframer_sum_check.sv -----
// Length-prefixed packet deframer with an 8-bit additive payload checksum.
// Top level; depends on pdsc_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_rx_byte): one received byte per
//   request. Output channel (o_out_valid / i_out_ready): one result per request
//   with kind, data byte, byte index, packet length, async flag and last.
//   Configuration: APB-style write of sync header (0x0), async header (0x4)
//   and max length (0x8); pready is always high.
//   Header, length and payload bytes are taken one per cycle while the output is
//   free and give no result. A bad header, bad length or bad checksum gives one
//   error result in the cycle after the byte. A good checksum byte starts a
//   readout of the payload memory: one payload result per cycle while the
//   receiver accepts, each byte read into the memory output register and then
//   into the output register; input is held off until the last result is loaded.
//   An empty packet gives a single result in the cycle after its checksum.
//   Throughput: one byte per cycle outside readout if the output is free; readout
//   uses the single read port of the payload memory. A stalled receiver holds the
//   output register and, with it, the input. Reset returns the parser to header
//   search and restores register defaults; the payload memory is not cleared.
module packet_deframer_sum_check
    import pdsc_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [BYTE_W-1:0]   i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KIND_W-1:0]   o_kind,
    output logic [BYTE_W-1:0]   o_data_byte,
    output logic [IDX_W-1:0]    o_byte_index,
    output logic [LEN_W-1:0]    o_packet_length,
    output logic                o_async_flag,
    output logic                o_last,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [LEN_W-1:0] MAX_P = LEN_W'(MAX_PAYLOAD);

    logic [BYTE_W-1:0] r_sync_hdr, r_async_hdr;
    logic [LEN_W-1:0]  r_max_len;

    t_state            r_state, n_state;
    logic              r_async, n_async;
    logic [LEN_W-1:0]  r_exp_len, n_exp_len;
    logic [LEN_W-1:0]  r_fill, n_fill;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [LEN_W-1:0]  r_emit_idx, n_emit_idx;

    logic              r_out_valid, n_out_valid;
    t_kind             r_kind, n_kind;
    logic [BYTE_W-1:0] r_data, n_data;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_aflag, n_aflag;
    logic              r_last, n_last;

    logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] r_mem_q;
    logic              mem_we;
    logic [AW-1:0]     wr_addr, rd_addr;

    logic              out_free, in_fire, cfg_wr;
    logic [LEN_W-1:0]  limit;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state != ST_EMIT) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign limit      = (r_max_len < MAX_P) ? r_max_len : MAX_P;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            REG_SYNC_HDR:  prdata = {24'b0, r_sync_hdr};
            REG_ASYNC_HDR: prdata = {24'b0, r_async_hdr};
            REG_MAX_LEN:   prdata = {26'b0, r_max_len};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_hdr  <= SYNC_HDR_RST;
            r_async_hdr <= ASYNC_HDR_RST;
            r_max_len   <= MAX_LEN_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SYNC_HDR:  r_sync_hdr  <= pwdata[BYTE_W-1:0];
                REG_ASYNC_HDR: r_async_hdr <= pwdata[BYTE_W-1:0];
                REG_MAX_LEN:   r_max_len   <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_async     = r_async;
        n_exp_len   = r_exp_len;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_emit_idx  = r_emit_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind      = r_kind;
        n_data      = r_data;
        n_idx       = r_idx;
        n_len       = r_len;
        n_aflag     = r_aflag;
        n_last      = r_last;
        mem_we      = 1'b0;

        case (r_state)
            ST_LEN: begin
                if (in_fire) begin
                    if (i_rx_byte > {2'b0, limit}) begin
                        n_state     = ST_HDR;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_LEN_ERR;
                        n_data      = '0;
                        n_idx       = '0;
                        n_len       = '0;
                        n_aflag     = 1'b0;
                        n_last      = 1'b1;
                    end else begin
                        n_exp_len = i_rx_byte[LEN_W-1:0];
                        n_fill    = '0;
                        n_sum     = '0;
                        n_state   = ST_PAY;
                    end
                end
            end
            ST_PAY: begin
                if (in_fire) begin
                    if (r_fill >= r_exp_len) begin
                        n_state     = ST_HDR;
                        n_out_valid = 1'b1;
                        n_data      = '0;
                        n_idx       = '0;
                        n_last      = 1'b1;
                        n_len       = '0;
                        n_aflag     = 1'b0;
                        if (r_sum != i_rx_byte) begin
                            n_kind = KIND_SUM_ERR;
                        end else if (r_exp_len == '0) begin
                            n_kind  = KIND_EMPTY;
                            n_aflag = r_async;
                        end else begin
                            n_out_valid = r_out_valid && !i_out_ready;
                            n_state     = ST_EMIT;
                            n_emit_idx  = '0;
                        end
                    end else begin
                        mem_we = (r_fill < MAX_P);
                        n_fill = r_fill + LEN_W'(1);
                        n_sum  = r_sum + i_rx_byte;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_PAYLOAD;
                    n_data      = r_mem_q;
                    n_idx       = r_emit_idx[IDX_W-1:0];
                    n_len       = r_exp_len;
                    n_aflag     = r_async;
                    n_last      = (r_emit_idx == r_exp_len - LEN_W'(1));
                    n_emit_idx  = r_emit_idx + LEN_W'(1);
                    if (n_last) begin
                        n_state = ST_HDR;
                    end
                end
            end
            default: begin
                if (in_fire) begin
                    if (i_rx_byte == r_sync_hdr) begin
                        n_async = 1'b0;
                        n_state = ST_LEN;
                    end else if (i_rx_byte == r_async_hdr) begin
                        n_async = 1'b1;
                        n_state = ST_LEN;
                    end else begin
                        n_state     = ST_HDR;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_HDR_ERR;
                        n_data      = '0;
                        n_idx       = '0;
                        n_len       = '0;
                        n_aflag     = 1'b0;
                        n_last      = 1'b1;
                    end
                end
            end
        endcase
    end

    assign wr_addr = r_fill[AW-1:0];
    assign rd_addr = n_emit_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= i_rx_byte;
        end
        r_mem_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HDR;
            r_async     <= 1'b0;
            r_exp_len   <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_async     <= n_async;
            r_exp_len   <= n_exp_len;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_emit_idx  <= n_emit_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_data  <= n_data;
        r_idx   <= n_idx;
        r_len   <= n_len;
        r_aflag <= n_aflag;
        r_last  <= n_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_data_byte     = r_data;
    assign o_byte_index    = r_idx;
    assign o_packet_length = r_len;
    assign o_async_flag    = r_aflag;
    assign o_last          = r_last;

endmodule

// ----- bench/packet_deframer_sum_check_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for packet_deframer_sum_check: received bytes go in over valid/ready,
// results are checked against an in-bench deframer model, registers are set over APB.
// Depends on pdsc_pkg and the deframer RTL.
module packet_deframer_sum_check_tb;
    import pdsc_pkg::*;

    localparam int MAX_PAYLOAD   = 32;
    localparam int STALL_PCT     = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 100;
    localparam int NUM_SETTINGS  = 4;

    typedef enum logic [1:0] {
        AWAIT_HDR,
        AWAIT_LEN,
        IN_BODY
    } t_parse;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic [LEN_W-1:0]  len;
        logic              af;
        logic              last;
    } t_res;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              typed;
        t_kind             kind;
        logic              af;
    } t_row;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_v;
        logic [BYTE_W-1:0] async_v;
        logic [LEN_W-1:0]  max_v;
    } t_setting;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [BYTE_W-1:0]   i_rx_byte   = '0;
    logic                i_out_ready = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [PDATA_W-1:0]  pwdata      = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [KIND_W-1:0]   o_kind;
    logic [BYTE_W-1:0]   o_data_byte;
    logic [IDX_W-1:0]    o_byte_index;
    logic [LEN_W-1:0]    o_packet_length;
    logic                o_async_flag;
    logic                o_last;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    t_parse              parse_st   = AWAIT_HDR;
    logic                body_async = 1'b0;
    logic [LEN_W-1:0]    body_len   = '0;
    logic [LEN_W-1:0]    fill       = '0;
    logic [BYTE_W-1:0]   body_sum   = '0;
    logic [BYTE_W-1:0]   body_store [MAX_PAYLOAD];
    logic [BYTE_W-1:0]   sync_hdr   = SYNC_HDR_RST;
    logic [BYTE_W-1:0]   async_hdr  = ASYNC_HDR_RST;
    logic [LEN_W-1:0]    max_len    = MAX_LEN_RST;

    t_res     due_results [$];
    t_res     step_res [$];
    t_res     oldest;
    t_res     got;
    string    bad;
    int       mismatches = 0;
    int       sent       = 0;
    bit       quiet      = 1'b0;
    t_setting settings [NUM_SETTINGS];

    t_row dir_rows [25] = '{
        '{8'h00, 1'b1, KIND_HDR_ERR, 1'b0},
        '{8'hFF, 1'b1, KIND_HDR_ERR, 1'b0},
        '{8'h23, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h00, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h00, 1'b1, KIND_EMPTY,   1'b0},
        '{8'h2A, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h00, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h00, 1'b1, KIND_EMPTY,   1'b1},
        '{8'h2A, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h21, 1'b1, KIND_LEN_ERR, 1'b0},
        '{8'h23, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'hFF, 1'b1, KIND_LEN_ERR, 1'b0},
        '{8'h23, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h02, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'hFF, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h01, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h00, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h23, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h01, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h80, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h81, 1'b1, KIND_SUM_ERR, 1'b0},
        '{8'h2A, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h01, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'hAA, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'hAA, 1'b0, KIND_PAYLOAD, 1'b0}
    };

    packet_deframer_sum_check #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_byte_index   (o_byte_index),
        .o_packet_length(o_packet_length),
        .o_async_flag   (o_async_flag),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_res mk_res(t_kind k, logic [BYTE_W-1:0] d, logic [IDX_W-1:0] i,
                                    logic [LEN_W-1:0] n, logic a, logic l);
        t_res r;
        r.kind = k;
        r.data = d;
        r.idx  = i;
        r.len  = n;
        r.af   = a;
        r.last = l;
        return r;
    endfunction

    function automatic int len_limit();
        return (int'(max_len) < MAX_PAYLOAD) ? int'(max_len) : MAX_PAYLOAD;
    endfunction

    // advance the deframer model by one byte; results land in step_res
    function automatic void deframe(logic [BYTE_W-1:0] b);
        step_res.delete();
        case (parse_st)
            AWAIT_LEN: begin
                if (int'(b) > len_limit()) begin
                    parse_st = AWAIT_HDR;
                    step_res.push_back(mk_res(KIND_LEN_ERR, '0, '0, '0, 1'b0, 1'b1));
                end else begin
                    body_len = b[LEN_W-1:0];
                    fill     = '0;
                    body_sum = '0;
                    parse_st = IN_BODY;
                end
            end
            IN_BODY: begin
                if (fill >= body_len) begin
                    parse_st = AWAIT_HDR;
                    if (body_sum != b)
                        step_res.push_back(mk_res(KIND_SUM_ERR, '0, '0, '0, 1'b0, 1'b1));
                    else if (body_len == 0)
                        step_res.push_back(mk_res(KIND_EMPTY, '0, '0, '0, body_async, 1'b1));
                    else
                        for (int k = 0; k < int'(body_len); k++)
                            step_res.push_back(mk_res(KIND_PAYLOAD, body_store[k], IDX_W'(k),
                                                      body_len, body_async,
                                                      k == int'(body_len) - 1));
                end else begin
                    body_store[fill] = b;
                    fill             = fill + 1'b1;
                    body_sum         = body_sum + b;
                end
            end
            default: begin
                if (b == sync_hdr) begin
                    body_async = 1'b0;
                    parse_st   = AWAIT_LEN;
                end else if (b == async_hdr) begin
                    body_async = 1'b1;
                    parse_st   = AWAIT_LEN;
                end else begin
                    parse_st = AWAIT_HDR;
                    step_res.push_back(mk_res(KIND_HDR_ERR, '0, '0, '0, 1'b0, 1'b1));
                end
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed = 1'b0,
                             input t_kind kind = KIND_PAYLOAD, input logic af = 1'b0);
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        deframe(b);
        if (typed)
            due_results.push_back(mk_res(kind, '0, '0, '0, af, 1'b1));
        else
            foreach (step_res[j]) due_results.push_back(step_res[j]);
        sent++;
        if (!quiet && $urandom_range(0, 99) < STALL_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx r, input logic [PDATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(r));
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_SYNC_HDR:  sync_hdr  = v[BYTE_W-1:0];
            REG_ASYNC_HDR: async_hdr = v[BYTE_W-1:0];
            REG_MAX_LEN:   max_len   = v[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // mostly well-formed frames; some noise bytes, bad lengths and corrupted sums
    task automatic send_frame(input bit full);
        int               r;
        int               q;
        int               lim;
        int               n;
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] pb;
        r   = $urandom_range(0, 99);
        q   = $urandom_range(0, 99);
        lim = len_limit();
        if (r < 10 && !full) begin
            send_byte(BYTE_W'($urandom));
            return;
        end
        send_byte($urandom_range(0, 1) ? async_hdr : sync_hdr);
        if (full || q < 5)
            n = lim;
        else if (q < 10)
            n = $urandom_range(lim + 1, 255);
        else
            n = $urandom_range(0, (lim < 8) ? lim : 8);
        send_byte(BYTE_W'(n));
        if (n > lim)
            return;
        s = '0;
        repeat (n) begin
            pb = BYTE_W'($urandom);
            s  = s + pb;
            send_byte(pb);
        end
        if (r < 18 && !full)
            s = s ^ BYTE_W'(1 << $urandom_range(0, 7));
        send_byte(s);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = mk_res(t_kind'(o_kind), o_data_byte, o_byte_index, o_packet_length,
                         o_async_flag, o_last);
            if (due_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result kind %0d data %h", o_kind,
                                        o_data_byte));
            end else begin
                oldest = due_results.pop_front();
                bad    = "";
                if (got.kind !== oldest.kind) bad = {bad, " kind"};
                if (got.data !== oldest.data) bad = {bad, " data_byte"};
                if (got.idx  !== oldest.idx)  bad = {bad, " byte_index"};
                if (got.len  !== oldest.len)  bad = {bad, " packet_length"};
                if (got.af   !== oldest.af)   bad = {bad, " async_flag"};
                if (got.last !== oldest.last) bad = {bad, " last"};
                if (bad != "")
                    flag_mismatch($sformatf(
                        "%s: got %0d/%h/%0d/%0d/%b/%b want %0d/%h/%0d/%0d/%b/%b",
                        bad, got.kind, got.data, got.idx, got.len, got.af, got.last,
                        oldest.kind, oldest.data, oldest.idx, oldest.len, oldest.af,
                        oldest.last));
            end
        end
        i_out_ready <= quiet || ($urandom_range(0, 99) >= STALL_PCT);
    end

    initial begin
        settings[0] = '{8'h00, 8'hFF, 6'd32};
        settings[1] = '{8'hFF, 8'h00, 6'd0};
        settings[2] = '{8'h5A, 8'h5A, 6'd17};
        settings[3] = '{BYTE_W'($urandom), BYTE_W'($urandom), LEN_W'($urandom_range(1, 32))};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[j])
            send_byte(dir_rows[j].b, dir_rows[j].typed, dir_rows[j].kind, dir_rows[j].af);
        for (int p = 0; p <= NUM_SETTINGS; p++) begin
            if (p > 0) begin
                settle();
                apb_write(REG_SYNC_HDR, PDATA_W'(settings[p-1].sync_v));
                apb_write(REG_ASYNC_HDR, PDATA_W'(settings[p-1].async_v));
                apb_write(REG_MAX_LEN, PDATA_W'(settings[p-1].max_v));
            end
            quiet = (p == 2);
            sent  = 0;
            send_frame(1'b1);
            while (sent < PHASE_BYTES) send_frame(1'b0);
        end
        settle();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/pdsc_pkg.sv
hdl/packet_deframer_sum_check.sv
bench/packet_deframer_sum_check_tb.sv
